>>> rtl/fela_pkg.sv
// Package for the free extent list allocator: payload structs, memory entry
// layout, operation and status codes. No dependencies.
package fela_pkg;

    localparam int BLOCK_W = 12;
    localparam int VOL_W   = 13;

    localparam logic [VOL_W-1:0]   VOL_RESET = 13'd4096;
    localparam logic [BLOCK_W-1:0] COUNT_MAX = 12'hFFF;

    // operation codes
    localparam logic [1:0] OP_FORMAT  = 2'd0;
    localparam logic [1:0] OP_ALLOC   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOSPACE     = 2'd1;
    localparam logic [1:0] ST_BADBLOCK    = 2'd2;
    localparam logic [1:0] ST_UNFORMATTED = 2'd3;

    typedef struct packed {
        logic [1:0]         operation;
        logic [BLOCK_W-1:0] block;
    } in_t;

    typedef struct packed {
        logic [BLOCK_W-1:0] block_number;
        logic [BLOCK_W-1:0] free_count;
        logic [1:0]         status;
    } out_t;

    // one extent descriptor, stored at the extent's start block
    typedef struct packed {
        logic [BLOCK_W-1:0] link;
        logic [BLOCK_W-1:0] length;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> rtl/fela_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module fela_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/fela_core.sv
// Allocator sequencer: head pointer, free count, format flag and the
// read-modify-write of the extent memory. Depends on fela_pkg.
module fela_core #(
    parameter int MAX_BLOCKS = 4096
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [fela_pkg::VOL_W-1:0]              vol_blocks,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  fela_pkg::in_t                           in_data,
    input  logic                                    slot_free,
    output logic                                    res_valid,
    output fela_pkg::out_t                          res_data,
    output logic                                    mem_we,
    output logic [$clog2((MAX_BLOCKS > 4096) ? 4096 : MAX_BLOCKS)-1:0] mem_waddr,
    output fela_pkg::entry_t                        mem_wdata,
    output logic [$clog2((MAX_BLOCKS > 4096) ? 4096 : MAX_BLOCKS)-1:0] mem_raddr,
    input  fela_pkg::entry_t                        mem_rdata
);
    import fela_pkg::*;

    localparam int DEPTH = (MAX_BLOCKS > 4096) ? 4096 : MAX_BLOCKS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [VOL_W-1:0] SIZE_CAP = VOL_W'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_ALLOC
    } state_t;

    state_t             state_reg, state_next;
    logic [BLOCK_W-1:0] head_reg, head_next;
    logic [BLOCK_W-1:0] free_reg, free_next;
    logic               fmt_reg, fmt_next;

    logic               accept;
    logic [VOL_W-1:0]   eff_size;
    logic [BLOCK_W-1:0] avail;
    logic [BLOCK_W-1:0] free_inc;
    logic [BLOCK_W-1:0] free_dec;

    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign mem_raddr = head_reg[AW-1:0];

    assign eff_size = (vol_blocks > SIZE_CAP) ? SIZE_CAP : vol_blocks;
    assign avail    = (eff_size >= VOL_W'(2)) ? BLOCK_W'(eff_size - VOL_W'(1)) : '0;
    assign free_inc = (free_reg != COUNT_MAX) ? free_reg + BLOCK_W'(1) : free_reg;
    assign free_dec = (free_reg != '0) ? free_reg - BLOCK_W'(1) : free_reg;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        free_next  = free_reg;
        fmt_next   = fmt_reg;
        mem_we     = 1'b0;
        mem_waddr  = head_reg[AW-1:0];
        mem_wdata  = '0;
        res_valid  = 1'b0;
        res_data   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_valid           = 1'b1;
                    res_data.free_count = free_reg;
                    res_data.status     = ST_OK;
                    if (in_data.operation == OP_FORMAT)
                    begin
                        fmt_next            = 1'b1;
                        free_next           = avail;
                        res_data.free_count = avail;
                        head_next           = '0;
                        if (avail != '0)
                        begin
                            head_next        = BLOCK_W'(1);
                            mem_we           = 1'b1;
                            mem_waddr        = AW'(1);
                            mem_wdata.link   = '0;
                            mem_wdata.length = avail;
                        end
                    end
                    else if (!fmt_reg)
                    begin
                        res_data.free_count = '0;
                        res_data.status     = ST_UNFORMATTED;
                    end
                    else if (in_data.operation == OP_ALLOC)
                    begin
                        if (head_reg == '0)
                        begin
                            res_data.status = ST_NOSPACE;
                        end
                        else
                        begin
                            // head entry comes back from memory next cycle
                            res_valid  = 1'b0;
                            state_next = S_ALLOC;
                        end
                    end
                    else if (in_data.operation == OP_RELEASE)
                    begin
                        if (in_data.block == '0 || {1'b0, in_data.block} >= eff_size)
                        begin
                            res_data.status = ST_BADBLOCK;
                        end
                        else
                        begin
                            mem_we              = 1'b1;
                            mem_waddr           = in_data.block[AW-1:0];
                            mem_wdata.link      = head_reg;
                            mem_wdata.length    = BLOCK_W'(1);
                            head_next           = in_data.block;
                            free_next           = free_inc;
                            res_data.free_count = free_inc;
                        end
                    end
                end
            end
            S_ALLOC:
            begin
                state_next          = S_IDLE;
                res_valid           = 1'b1;
                res_data.status     = ST_OK;
                free_next           = free_dec;
                res_data.free_count = free_dec;
                if (mem_rdata.length <= BLOCK_W'(1))
                begin
                    // pop the head extent
                    res_data.block_number = head_reg;
                    head_next             = mem_rdata.link;
                end
                else
                begin
                    // hand out the last block, shorten the extent
                    mem_we                = 1'b1;
                    mem_wdata.link        = mem_rdata.link;
                    mem_wdata.length      = mem_rdata.length - BLOCK_W'(1);
                    res_data.block_number = head_reg + mem_rdata.length - BLOCK_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            free_reg  <= '0;
            fmt_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            free_reg  <= free_next;
            fmt_reg   <= fmt_next;
        end
    end

`ifndef SYNTHESIS
    a_alloc_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ALLOC |=> state_reg == S_IDLE)
        else $error("allocate held the sequencer longer than one cycle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> slot_free)
        else $error("result produced while output register is occupied");

    a_head_needs_format: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg != '0 |-> fmt_reg)
        else $error("nonempty free list before format");

    a_alloc_writes_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC && mem_we) |-> mem_waddr == head_reg[AW-1:0])
        else $error("allocate write-back to wrong entry");

    a_alloc_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fmt_reg && in_data.operation == OP_ALLOC && head_reg != '0)
        |=> (state_reg == S_ALLOC && $stable(head_reg)))
        else $error("allocate did not enter memory read cycle");
`endif

endmodule

>>> rtl/free_extent_list_allocator.sv
// Top level of the free extent list allocator: configuration register,
// output register, extent memory and sequencer. Depends on fela_pkg,
// fela_ram and fela_core.
//
//  channel  | valid     | ready     | payload
//  ---------+-----------+-----------+-------------------------------
//  cfg      | cfg_valid | cfg_ready | cfg_data (volume_blocks)
//  in       | in_valid  | in_ready  | in_data  (operation, block)
//  out      | out_valid | out_ready | out_data (block_number, free_count, status)
//
// Format, release, error answers and unused codes are answered from S_IDLE; an
// allocate on a nonempty list passes through S_ALLOC for the extent memory read.
// Reset clears the free list, count and format flag; the memory is not cleared.
// in_ready drops while an allocate is in flight or a result waits in the
// output register without out_ready. cfg_ready is always high.
module free_extent_list_allocator #(
    parameter int MAX_BLOCKS = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fela_pkg::VOL_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  fela_pkg::in_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output fela_pkg::out_t                out_data
);
    import fela_pkg::*;

    localparam int DEPTH = (MAX_BLOCKS > 4096) ? 4096 : MAX_BLOCKS;
    localparam int AW    = $clog2(DEPTH);

    logic [VOL_W-1:0] vol_reg;
    logic             out_valid_reg;
    out_t             out_data_reg;

    logic             slot_free;
    logic             res_valid;
    out_t             res_data;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    entry_t           mem_wdata;
    logic [AW-1:0]    mem_raddr;
    entry_t           mem_rdata;

    assign cfg_ready = 1'b1;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_reg       <= VOL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                vol_reg <= cfg_data;
            end
            if (res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res_data;
        end
    end

    fela_core #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .vol_blocks (vol_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .slot_free  (slot_free),
        .res_valid  (res_valid),
        .res_data   (res_data),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    fela_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_extent_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
